>>> hdl/cvlb_pkg.sv
// ----------------------------------------------------------------------------
// cvlb_pkg
// Shared types and constants of the 3x3 convolution line buffer.
// ----------------------------------------------------------------------------
package cvlb_pkg;

  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int WINDOW_SIZE  = 3;
  localparam int WAIT_TICKS   = (IMAGE_WIDTH * (WINDOW_SIZE - 1) + WINDOW_SIZE) / 2;

  localparam int COL_W     = $clog2(IMAGE_WIDTH);
  localparam int ROW_W     = $clog2(IMAGE_HEIGHT + 1);  // row index saturates at the height
  localparam int CNT_W     = $clog2(WAIT_TICKS + 1);
  localparam int PIX_W     = 8;
  localparam int KERNEL_W  = 24;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 16;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 2'd2;

  typedef logic [PIX_W-1:0]    pixel_t;
  typedef logic [KERNEL_W-1:0] kernel_t;
  typedef logic [COL_W-1:0]    col_t;

  typedef struct packed {
    logic [5:0] dest;
    logic [4:0] stream_id;
    logic [1:0] user;
    logic       strobe;
    logic       keep;
  } side_t;

  // two stored image rows for one column; row0 is the older one
  typedef struct packed {
    pixel_t row1;
    pixel_t row0;
  } line_t;

  // window indexed [row][col]; row 0 oldest, col 0 oldest
  typedef pixel_t [WINDOW_SIZE-1:0][WINDOW_SIZE-1:0] win_t;

  typedef struct packed {
    logic  valid;
    logic  zero;
    logic  last;
    side_t side;
  } ctrl_t;

endpackage

>>> hdl/cvlb_line_ram.sv
// ----------------------------------------------------------------------------
// cvlb_line_ram
// Line store: one entry per image column holding the two previous rows.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cvlb_line_ram
  import cvlb_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  col_t  waddr,
  input  line_t wdata,
  input  col_t  raddr,
  output line_t rdata
);

  line_t mem [IMAGE_WIDTH];
  line_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/cvlb_window.sv
// ----------------------------------------------------------------------------
// cvlb_window
// Front stage: raster position, drop and flush counters, line store update
// and the 3x3 pixel window. Issues one control beat per emitted result.
// ----------------------------------------------------------------------------
module cvlb_window
  import cvlb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  logic   in_op,
  input  pixel_t in_pixel,
  input  side_t  in_side,
  input  line_t  rd_line,
  output col_t   raddr,
  output logic   we,
  output col_t   waddr,
  output line_t  wdata,
  output win_t   win,
  output ctrl_t  s1
);

  col_t             col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] drop_r, drop_nxt;
  logic [CNT_W-1:0] flush_r, flush_nxt;
  side_t            saved_r, saved_nxt;
  win_t             win_r;
  ctrl_t            s1_r, s1_nxt;
  logic             accept;
  logic             in_region;
  logic             last_flush;

  assign accept     = in_valid && adv;
  assign last_flush = flush_r >= CNT_W'(WAIT_TICKS - 1);
  assign in_region  = (row_r >= ROW_W'(2)) && (row_r < ROW_W'(IMAGE_HEIGHT - 2)) &&
                      (col_r >= COL_W'(2)) && (col_r < COL_W'(IMAGE_WIDTH - 2));

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drop_nxt  = drop_r;
    flush_nxt = flush_r;
    saved_nxt = saved_r;
    s1_nxt    = '0;
    we        = 1'b0;
    if (accept) begin
      if (in_op == OP_FLUSH) begin
        s1_nxt.valid = 1'b1;
        s1_nxt.zero  = 1'b1;
        s1_nxt.last  = last_flush;
        s1_nxt.side  = saved_r;
        if (last_flush) begin
          col_nxt   = '0;
          row_nxt   = '0;
          drop_nxt  = '0;
          flush_nxt = '0;
        end else begin
          flush_nxt = flush_r + CNT_W'(1);
        end
      end else begin
        we        = 1'b1;
        saved_nxt = in_side;
        s1_nxt.valid = (drop_r >= CNT_W'(WAIT_TICKS));
        s1_nxt.zero  = !in_region;
        s1_nxt.side  = in_side;
        if (drop_r < CNT_W'(WAIT_TICKS)) begin
          drop_nxt = drop_r + CNT_W'(1);
        end
        if (col_r == COL_W'(IMAGE_WIDTH - 1)) begin
          col_nxt = '0;
          if (row_r < ROW_W'(IMAGE_HEIGHT)) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  // read ahead at the column of the next pixel
  assign raddr      = col_nxt;
  assign waddr      = col_r;
  assign wdata.row1 = in_pixel;
  assign wdata.row0 = rd_line.row1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drop_r  <= '0;
      flush_r <= '0;
      saved_r <= '0;
      win_r   <= '0;
      s1_r    <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drop_r  <= drop_nxt;
      flush_r <= flush_nxt;
      saved_r <= saved_nxt;
      if (accept && in_op == OP_PIXEL) begin
        for (int r = 0; r < WINDOW_SIZE; r++) begin
          for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
            win_r[r][c] <= win_r[r][c+1];
          end
        end
        win_r[0][WINDOW_SIZE-1] <= rd_line.row0;
        win_r[1][WINDOW_SIZE-1] <= rd_line.row1;
        win_r[2][WINDOW_SIZE-1] <= in_pixel;
      end
      if (adv) begin
        s1_r <= s1_nxt;
      end
    end
  end

  assign win = win_r;
  assign s1  = s1_r;

`ifndef NO_ASSERTIONS
  a_drop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r <= CNT_W'(WAIT_TICKS))
    else $error("drop counter past wait count");

  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r < CNT_W'(WAIT_TICKS))
    else $error("flush counter past wait count");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_FLUSH && last_flush) |=>
      (col_r == '0 && row_r == '0 && drop_r == '0 && flush_r == '0))
    else $error("frame state not cleared after final flush");

  a_no_emit_while_dropping: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_PIXEL && drop_r < CNT_W'(WAIT_TICKS)) |=> !s1_r.valid)
    else $error("result issued during drop phase");
`endif

endmodule

>>> hdl/cvlb_mac.sv
// ----------------------------------------------------------------------------
// cvlb_mac
// Kernel registers, nine tap products, 16-bit wrapped sum, clamp and the
// result register. Generates the pipeline advance.
// ----------------------------------------------------------------------------
module cvlb_mac
  import cvlb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  kernel_t              cfg_wdata,
  input  win_t                 win,
  input  ctrl_t                s1,
  input  logic                 out_stall,
  output logic                 adv,
  output logic                 out_valid,
  output pixel_t               out_pixel,
  output side_t                out_side,
  output logic                 out_last
);

  typedef logic [ACC_W-1:0] prod_t;
  typedef prod_t [WINDOW_SIZE-1:0][WINDOW_SIZE-1:0] prod_arr_t;

  kernel_t   kernel_r [WINDOW_SIZE];
  prod_arr_t prod_r, prod_nxt;
  ctrl_t     s2_r;
  logic      out_valid_r;
  pixel_t    out_pixel_r, out_pixel_nxt;
  side_t     out_side_r;
  logic      out_last_r;
  prod_t     acc;

  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < WINDOW_SIZE; r++) begin
        kernel_r[r] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_TOP:    kernel_r[0] <= cfg_wdata;
        CFG_KERNEL_MID:    kernel_r[1] <= cfg_wdata;
        CFG_KERNEL_BOTTOM: kernel_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [PIX_W-1:0] coef;
    logic signed [2*PIX_W:0] prod;
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      for (int c = 0; c < WINDOW_SIZE; c++) begin
        coef = $signed(kernel_r[r][PIX_W*c +: PIX_W]);
        prod = coef * $signed({1'b0, win[r][c]});
        prod_nxt[r][c] = prod[ACC_W-1:0];
      end
    end
  end

  // sum wraps at 16 bits; a negative sum clamps to zero
  always_comb begin
    acc = '0;
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      for (int c = 0; c < WINDOW_SIZE; c++) begin
        acc = acc + prod_r[r][c];
      end
    end
    if (s2_r.zero || acc[ACC_W-1]) begin
      out_pixel_nxt = '0;
    end else begin
      out_pixel_nxt = acc[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_r        <= s1;
      out_valid_r <= s2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r      <= prod_nxt;
      out_pixel_r <= out_pixel_nxt;
      out_side_r  <= s2_r.side;
      out_last_r  <= s2_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_side  = out_side_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_pixel_r == '0))
    else $error("final flush result not zero");

  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_r.valid && s2_r.last) |-> s2_r.zero)
    else $error("last flag on a pixel result");

  // products of unwritten line entries may be unknown, so compare exactly
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ((s2_r === $past(s2_r)) && (prod_r === $past(prod_r))))
    else $error("pipeline moved while stalled");
`endif

endmodule

>>> hdl/conv3x3_line_buffer.sv
// ----------------------------------------------------------------------------
// conv3x3_line_buffer
// 3x3 convolution over a raster stream of 8-bit pixels, with line store,
// frame-start drop and end-of-frame flush.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | op, pixel, keep, strobe, user, id, dest
//  out      | out_valid/out_stall | result_pixel, sideband, last
//  cfg      | cfg_we              | cfg_index, cfg_wdata (kernel rows)
//
//  One beat per clock in and out unless the output stalls; an input beat
//  passes the window register, product register and result register.
//  The line store read is issued ahead, at the column of the next pixel.
//  in_stall follows out_stall while a result waits; the whole pipeline holds.
//  Synchronous active-low reset; no clearing pass, so line store contents
//  can be read before being written.
// ----------------------------------------------------------------------------
module conv3x3_line_buffer
  import cvlb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [KERNEL_W-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [7:0]              in_pixel,
  input  logic                    in_keep_in,
  input  logic                    in_strobe_in,
  input  logic [1:0]              in_user_in,
  input  logic [4:0]              in_stream_id_in,
  input  logic [5:0]              in_dest_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [7:0]       out_result_pixel,
  output logic                    out_keep_out,
  output logic                    out_strobe_out,
  output logic [1:0]              out_user_out,
  output logic [4:0]              out_stream_id_out,
  output logic [5:0]              out_dest_out,
  output logic                    out_last
);

  logic   adv;
  side_t  in_side;
  side_t  res_side;
  pixel_t res_pixel;
  line_t  rd_line;
  line_t  wdata;
  col_t   raddr;
  col_t   waddr;
  logic   we;
  win_t   win;
  ctrl_t  s1;

  assign in_side.keep      = in_keep_in;
  assign in_side.strobe    = in_strobe_in;
  assign in_side.user      = in_user_in;
  assign in_side.stream_id = in_stream_id_in;
  assign in_side.dest      = in_dest_in;

  assign in_stall = !adv;

  cvlb_line_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_line)
  );

  cvlb_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_pixel (in_pixel),
    .in_side  (in_side),
    .rd_line  (rd_line),
    .raddr    (raddr),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .win      (win),
    .s1       (s1)
  );

  cvlb_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .win       (win),
    .s1        (s1),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_pixel (res_pixel),
    .out_side  (res_side),
    .out_last  (out_last)
  );

  assign out_result_pixel  = $signed(res_pixel);
  assign out_keep_out      = res_side.keep;
  assign out_strobe_out    = res_side.strobe;
  assign out_user_out      = res_side.user;
  assign out_stream_id_out = res_side.stream_id;
  assign out_dest_out      = res_side.dest;

endmodule
